FILE: rtl/rfcd_pkg.sv
// Shared types and constants for the RS-485 frame command decoder.
`timescale 1ns / 1ps
`default_nettype none
package rfcd_pkg;

  localparam logic [7:0] HDR0        = 8'hFF;
  localparam logic [7:0] HDR1        = 8'h10;
  localparam logic [7:0] HDR2        = 8'h11;
  localparam logic [7:0] CMD_STOP    = 8'hCC;
  localparam logic [7:0] CMD_RISE    = 8'hDD;
  localparam logic [7:0] CMD_DECLINE = 8'hEE;
  localparam logic [7:0] CMD_GROUP   = 8'hAA;
  localparam logic [7:0] ADDR_BCAST  = 8'h00;

  // Count at which the byte four back from the next write is available.
  localparam logic [2:0] CNT_CHECK   = 3'd4;
  localparam logic [2:0] CNT_LAST    = 3'd7;

  localparam logic [1:0] ACT_STOP    = 2'd0;
  localparam logic [1:0] ACT_RISE    = 2'd1;
  localparam logic [1:0] ACT_DECLINE = 2'd2;
  localparam logic [1:0] ACT_SETID   = 2'd3;

  localparam logic REG_OWN_ID   = 1'b0;
  localparam logic REG_UNLOCKED = 1'b1;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
  } frame_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] addr;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/rfcd_queue.sv
// Two-entry frame queue between the byte front end and the command back end.
`timescale 1ns / 1ps
`default_nettype none
module rfcd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rfcd_pkg::frame_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output rfcd_pkg::frame_t     data_o,
  output logic                 empty_o
);
  import rfcd_pkg::*;

  frame_t     mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rfcd_front.sv
// Byte front end: collects received bytes and detects headed frames.
`timescale 1ns / 1ps
`default_nettype none
module rfcd_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             full_o,
  output logic             frm_push_o,
  output rfcd_pkg::frame_t frm_o,
  input  wire logic        frm_full_i
);
  import rfcd_pkg::*;

  logic [2:0] cnt_q, cnt_d;
  logic [7:0] hist_q [4];
  logic       accept;
  logic       hdr_hit;
  logic       hdr_ok;

  assign full_o  = frm_full_i;
  assign accept  = push_i && !frm_full_i;
  assign hdr_hit = (cnt_q >= CNT_CHECK) && (hist_q[3] == HDR0);
  assign hdr_ok  = (hist_q[2] == HDR1) && (hist_q[1] == HDR2);

  assign frm_push_o = accept && hdr_hit && hdr_ok;
  assign frm_o.addr = hist_q[0];
  assign frm_o.cmd  = rx_byte_i;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (hdr_hit || cnt_q == CNT_LAST) begin
        cnt_d = 3'd0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift line of the four previous bytes, newest at tap 0.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= rx_byte_i;
      hist_q[1] <= hist_q[0];
      hist_q[2] <= hist_q[1];
      hist_q[3] <= hist_q[2];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rfcd_back.sv
// Command back end: applies lock and address rules and queues results.
`timescale 1ns / 1ps
`default_nettype none
module rfcd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_wdata_i,
  input  wire rfcd_pkg::frame_t frm_i,
  input  wire logic             frm_empty_i,
  output logic                  frm_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output rfcd_pkg::result_t     res_o
);
  import rfcd_pkg::*;

  logic [7:0] own_id_q;
  logic       unlocked_q;
  result_t    mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       res_full;
  logic       act_vld;
  logic [1:0] act;
  logic       do_wr, do_rd;

  always_comb begin
    act_vld = 1'b0;
    act     = ACT_STOP;
    if (unlocked_q) begin
      if (frm_i.addr == ADDR_BCAST) begin
        case (frm_i.cmd)
          CMD_STOP: begin
            act_vld = 1'b1;
            act     = ACT_STOP;
          end
          CMD_RISE: begin
            act_vld = 1'b1;
            act     = ACT_RISE;
          end
          CMD_DECLINE: begin
            act_vld = 1'b1;
            act     = ACT_DECLINE;
          end
          default: begin
            act_vld = 1'b0;
            act     = ACT_STOP;
          end
        endcase
      end else if (frm_i.cmd == CMD_GROUP && frm_i.addr != own_id_q) begin
        act_vld = 1'b1;
        act     = ACT_SETID;
      end
    end
  end

  assign res_full  = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign frm_pop_o = !frm_empty_i && !res_full;
  assign do_wr     = frm_pop_o && act_vld;
  assign do_rd     = pop_i && !empty_o;
  assign res_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? ~wptr_q : wptr_q;
    rptr_d = do_rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= 8'd0;
      unlocked_q <= 1'b1;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_OWN_ID) begin
        own_id_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_UNLOCKED) begin
        unlocked_q <= cfg_wdata_i[0];
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= '{action: act, addr: frm_i.addr};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rs485_frame_command_decoder_top.sv
// Top level of the RS-485 frame command decoder.
// Path: the byte that ends a frame is registered in the frame queue, then its result in the result queue.
// Throughput: one byte per cycle; the front end stalls only when the two-entry
// frame queue is full, which happens only after the two-entry result queue has filled.
// Reset: rst_ni low clears the byte count, both queues, own_id to 0 and unlocked to 1.
`timescale 1ns / 1ps
`default_nettype none
module rs485_frame_command_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      action_o,
  output logic [7:0]      frame_addr_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import rfcd_pkg::*;

  frame_t  frm_in;
  frame_t  frm_out;
  logic    frm_push;
  logic    frm_full;
  logic    frm_pop;
  logic    frm_empty;
  result_t res;

  rfcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .frm_push_o (frm_push),
    .frm_o      (frm_in),
    .frm_full_i (frm_full)
  );

  rfcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frm_push),
    .data_i  (frm_in),
    .full_o  (frm_full),
    .pop_i   (frm_pop),
    .data_o  (frm_out),
    .empty_o (frm_empty)
  );

  rfcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frm_i       (frm_out),
    .frm_empty_i (frm_empty),
    .frm_pop_o   (frm_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign action_o     = res.action;
  assign frame_addr_o = res.addr;

endmodule
`default_nettype wire

FILE: rtl/rfcd_checker.sv
// Port-level checker for the RS-485 frame command decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rfcd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] action_o,
  input wire logic [7:0] frame_addr_o
);
  import rfcd_pkg::*;

  // Hold a waiting result until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(action_o) && $stable(frame_addr_o)))
    else $error("waiting result changed before pop");

  a_setid_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == ACT_SETID) |-> (frame_addr_o != ADDR_BCAST))
    else $error("set-id result with broadcast address");

  a_motor_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o != ACT_SETID) |-> (frame_addr_o == ADDR_BCAST))
    else $error("motor result with non-broadcast address");

  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> empty)
    else $error("result shown during reset");

endmodule

bind rs485_frame_command_decoder_top rfcd_checker u_rfcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .action_o     (action_o),
  .frame_addr_o (frame_addr_o)
);
`default_nettype wire
